// ----- rtl/lcal_pkg.sv -----
package lcal_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LOG_LEVELS = 10;
	localparam int NODE_W     = 10;
	localparam int LINK_W     = 11;
	localparam int DEPTH_W    = 10;
	localparam int ACT_W      = 2;
	localparam int LVL_W      = $clog2(LOG_LEVELS);
	localparam int TBL_AW     = LVL_W + NODE_W;
	localparam int TBL_DEPTH  = LOG_LEVELS * MAX_NODES;

	localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(MAX_NODES);

	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

	typedef enum logic [1:0] {
		K_LOAD,
		K_BUILD,
		K_QUERY
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [NODE_W-1:0]  node;
		logic [LINK_W-1:0]  link;
		logic [DEPTH_W-1:0] depth;
		logic [LINK_W-1:0]  count;
	} lcal_req_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} lcal_hs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_A,
		ST_BLD_B,
		ST_BLD_W,
		ST_Q_DEP,
		ST_P1_RD,
		ST_P1_A,
		ST_P1_D,
		ST_P1_END,
		ST_P2_RD,
		ST_P2_C,
		ST_FIN_RD,
		ST_FIN_C,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/lcal_front.sv -----
module lcal_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lcal_pkg::ACT_W-1:0]   action,
	input  logic [lcal_pkg::NODE_W-1:0]  node,
	input  logic [lcal_pkg::LINK_W-1:0]  other,
	input  logic [lcal_pkg::DEPTH_W-1:0] depth,
	input  logic [lcal_pkg::LINK_W-1:0]  node_count,
	input  logic                        q_ready,
	output logic                        q_push,
	output lcal_pkg::lcal_req_t          q_req
);
	import lcal_pkg::*;

	logic node_ok;
	logic other_ok;
	logic keep;

	assign node_ok  = {1'b0, node} < NO_NODE;
	assign other_ok = other < NO_NODE;
	assign in_ready = q_ready;

	always_comb begin
		keep        = 1'b0;
		q_req.kind  = K_LOAD;
		q_req.node  = node;
		q_req.link  = other_ok ? other : NO_NODE;
		q_req.depth = depth;
		q_req.count = (node_count > NO_NODE) ? NO_NODE : node_count;
		case (action)
			ACT_LOAD: begin
				q_req.kind = K_LOAD;
				keep       = node_ok;
			end
			ACT_BUILD: begin
				q_req.kind = K_BUILD;
				keep       = 1'b1;
			end
			ACT_QUERY: begin
				q_req.kind = K_QUERY;
				keep       = node_ok && other_ok;
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = in_valid && q_ready && keep;

endmodule

// ----- rtl/lcal_queue.sv -----
module lcal_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lcal_pkg::lcal_req_t push_req,
	input  logic               pop,
	output lcal_pkg::lcal_hs_t  hs,
	output lcal_pkg::lcal_req_t head
);
	import lcal_pkg::*;

	lcal_req_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;
	logic       do_push;

	assign hs.valid = cnt_q != 2'd0;
	assign hs.ready = cnt_q != 2'd2;
	assign head     = slot_q[rd_q];
	assign do_pop   = pop && hs.valid;
	assign do_push  = push && hs.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_req;
	end

endmodule

// ----- rtl/lcal_back.sv -----
module lcal_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcal_pkg::lcal_hs_t           q_hs,
	input  lcal_pkg::lcal_req_t          head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lcal_pkg::NODE_W-1:0]  ancestor
);
	import lcal_pkg::*;

	logic [LINK_W-1:0]  tbl [0:TBL_DEPTH-1];
	logic [DEPTH_W-1:0] dep [0:MAX_NODES-1];

	state_t             state_q, state_d;
	logic [TBL_AW-1:0]  ta_addr, tb_addr, tw_addr;
	logic [LINK_W-1:0]  tw_data, ta_q, tb_q;
	logic               tw_en;
	logic [NODE_W-1:0]  da_addr, db_addr;
	logic [DEPTH_W-1:0] da_q, db_q;
	logic               dw_en;

	logic [NODE_W-1:0]  u_q, v_q, i_q, a_q, res_q, anc_q;
	logic [DEPTH_W-1:0] dv_q;
	logic [LVL_W-1:0]   lvl_q, lg_q, bj_q;
	logic [LINK_W-1:0]  cnt_q;
	logic               take_q;
	logic               out_valid_q;

	logic [DEPTH_W-1:0] dmax;
	logic [LVL_W-1:0]   lg_raw;
	logic               a_ok, b_ok;

	function automatic logic [LVL_W-1:0] flog2(input logic [DEPTH_W-1:0] d);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int k = 1; k < DEPTH_W; k++) begin
			if (d[k]) r = LVL_W'(k);
		end
		return r;
	endfunction

	assign a_ok      = ta_q < NO_NODE;
	assign b_ok      = tb_q < NO_NODE;
	assign dmax      = (da_q < db_q) ? db_q : da_q;
	assign lg_raw    = flog2(dmax);
	assign out_valid = out_valid_q;
	assign ancestor  = anc_q;

	always_ff @(posedge clk) begin
		if (tw_en) tbl[tw_addr] <= tw_data;
		ta_q <= tbl[ta_addr];
		tb_q <= tbl[tb_addr];
		if (dw_en) dep[head.node] <= head.depth;
		da_q <= dep[da_addr];
		db_q <= dep[db_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		ta_addr = {lvl_q, u_q};
		tb_addr = {lvl_q, v_q};
		tw_addr = {bj_q, i_q};
		tw_data = take_q ? ta_q : NO_NODE;
		tw_en   = 1'b0;
		da_addr = head.node;
		db_addr = head.link[NODE_W-1:0];
		dw_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_hs.valid) begin
					pop = 1'b1;
					case (head.kind)
						K_LOAD: begin
							tw_addr = {LVL_W'(0), head.node};
							tw_data = head.link;
							tw_en   = 1'b1;
							dw_en   = 1'b1;
						end
						K_BUILD: state_d = (LOG_LEVELS > 1) ? ST_BLD_A : ST_IDLE;
						K_QUERY: state_d = ST_Q_DEP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_BLD_A: begin
				ta_addr = {bj_q - LVL_W'(1), i_q};
				state_d = ST_BLD_B;
			end
			ST_BLD_B: begin
				ta_addr = {bj_q - LVL_W'(1), ta_q[NODE_W-1:0]};
				state_d = ST_BLD_W;
			end
			ST_BLD_W: begin
				tw_en = 1'b1;
				if (i_q == NODE_W'(MAX_NODES - 1) && bj_q == LVL_W'(LOG_LEVELS - 1))
					state_d = ST_IDLE;
				else
					state_d = ST_BLD_A;
			end
			ST_Q_DEP: state_d = ST_P1_RD;
			ST_P1_RD: state_d = ST_P1_A;
			ST_P1_A: begin
				da_addr = ta_q[NODE_W-1:0];
				if (a_ok) state_d = ST_P1_D;
				else if (lvl_q == '0) state_d = ST_P1_END;
				else state_d = ST_P1_RD;
			end
			ST_P1_D: state_d = (lvl_q == '0) ? ST_P1_END : ST_P1_RD;
			ST_P1_END: state_d = (u_q == v_q) ? ST_EMIT : ST_P2_RD;
			ST_P2_RD: state_d = ST_P2_C;
			ST_P2_C: state_d = (lvl_q == '0) ? ST_FIN_RD : ST_P2_RD;
			ST_FIN_RD: begin
				ta_addr = {LVL_W'(0), u_q};
				tb_addr = {LVL_W'(0), v_q};
				state_d = ST_FIN_C;
			end
			ST_FIN_C: state_d = (a_ok && ta_q == tb_q) ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!out_valid_q || out_ready)) anc_q <= res_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				u_q   <= head.node;
				v_q   <= head.link[NODE_W-1:0];
				cnt_q <= head.count;
				i_q   <= '0;
				bj_q  <= LVL_W'(1);
			end
			ST_BLD_B: take_q <= ({1'b0, i_q} < cnt_q) && a_ok;
			ST_BLD_W: begin
				i_q <= i_q + NODE_W'(1);
				if (i_q == NODE_W'(MAX_NODES - 1)) bj_q <= bj_q + LVL_W'(1);
			end
			ST_Q_DEP: begin
				if (da_q < db_q) begin
					u_q  <= v_q;
					v_q  <= u_q;
					dv_q <= da_q;
				end else begin
					dv_q <= db_q;
				end
				if (lg_raw > LVL_W'(LOG_LEVELS - 1)) begin
					lvl_q <= LVL_W'(LOG_LEVELS - 1);
					lg_q  <= LVL_W'(LOG_LEVELS - 1);
				end else begin
					lvl_q <= lg_raw;
					lg_q  <= lg_raw;
				end
			end
			ST_P1_A: begin
				a_q <= ta_q[NODE_W-1:0];
				if (!a_ok && lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
			end
			ST_P1_D: begin
				if (da_q >= dv_q) u_q <= a_q;
				if (lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
			end
			ST_P1_END: begin
				res_q <= u_q;
				lvl_q <= lg_q;
			end
			ST_P2_C: begin
				if (a_ok && b_ok && ta_q != tb_q) begin
					u_q <= ta_q[NODE_W-1:0];
					v_q <= tb_q[NODE_W-1:0];
				end
				if (lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
			end
			ST_FIN_C: res_q <= ta_q[NODE_W-1:0];
			default: ;
		endcase
	end

endmodule

// ----- rtl/lowest_common_ancestor_lifting.sv -----
// Query: order the two nodes by depth, lift the deeper one to the other's depth, then lift both
// while their ancestors differ and emit the common parent if they share one. Load: a single write
// in the back end. Build: per entry, two dependent reads of level j-1 and a write; one item runs at a time.
// Results leave through an output register; a two-entry queue decouples input from work.
// arst_n clears control state only; ancestor and depth memories are undefined until loaded.
module lowest_common_ancestor_lifting (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lcal_pkg::ACT_W-1:0]   action,
	input  logic [lcal_pkg::NODE_W-1:0]  node,
	input  logic [lcal_pkg::LINK_W-1:0]  other,
	input  logic [lcal_pkg::DEPTH_W-1:0] depth,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lcal_pkg::NODE_W-1:0]  ancestor,
	input  logic                        cfg_we,
	input  logic [lcal_pkg::LINK_W-1:0]  cfg_wdata
);
	import lcal_pkg::*;

	logic [LINK_W-1:0] node_count_q;
	logic              q_push;
	logic              pop;
	lcal_req_t         q_req;
	lcal_req_t         head;
	lcal_hs_t          q_hs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= LINK_W'(MAX_NODES);
		else if (cfg_we) node_count_q <= cfg_wdata;
	end

	lcal_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.node       (node),
		.other      (other),
		.depth      (depth),
		.node_count (node_count_q),
		.q_ready    (q_hs.ready),
		.q_push     (q_push),
		.q_req      (q_req)
	);

	lcal_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (q_req),
		.pop      (pop),
		.hs       (q_hs),
		.head     (head)
	);

	lcal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_hs      (q_hs),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ancestor  (ancestor)
	);

endmodule

// ----- rtl/lcal_checker.sv -----
module lcal_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] ancestor
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ancestor))
		else $error("result dropped or changed while stalled");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(ancestor))
		else $error("result payload unknown");

	a_ctl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready) && !$isunknown(out_valid))
		else $error("handshake control unknown");

endmodule

bind lowest_common_ancestor_lifting lcal_checker u_lcal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ancestor  (ancestor)
);
